FILE: sv/tleq_pkg.sv
package tleq_pkg;

  localparam int unsigned ENTRIES_DEF = 256;

  localparam int unsigned CFG_W   = 9;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned OUT_W   = 9;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RST = 9'd256;
  localparam logic [CFG_W-1:0] MAX_ACTIVE_RST     = 9'd16;

  localparam logic [KIND_W-1:0] KIND_ACTIVATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ID  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;
  localparam logic REG_MAX_ACTIVE     = 1'b1;

endpackage

FILE: sv/tleq_ram.sv
module tleq_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/two_list_expiration_queue.sv
// Two-list expiration queue over a pool of ENTRIES entries linked by index.
// Input channel (in_valid_i/in_ready_o) carries kind_i and element_id_i;
// output channel (out_valid_o/out_ready_i) carries one result per item:
// status_o, oldest_queued_o, queued_count_o, active_count_o.
// Items are worked one at a time by a sequencer around two link memories
// (next, and prev with the active flag), each with a registered read port.
// Activate: read, unlink, append, finish, result; a bad index goes straight
// to the result, a full list from the unlink step. Flush: read, unlink,
// append and finish for each active entry moved. Clear: a sweep over all
// ENTRIES entries, one memory entry written per cycle, then the result.
// in_ready_o rises in the same cycle as the result is registered, not earlier.
// After reset the same rebuild sweep runs over all ENTRIES entries
// with in_ready_o low; register writes are taken meanwhile.
// The result sits in an output register; while the receiver stalls, the
// block takes a new item and holds its finished result until the old one is
// transferred. APB registers, selected by paddr[2]: 0 entries_in_use
// (applied at the next clear), 1 max_active (read live at each activation).
module two_list_expiration_queue #(
  parameter int unsigned ENTRIES = tleq_pkg::ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tleq_pkg::KIND_W-1:0]  kind_i,
  input  logic [tleq_pkg::ID_W-1:0]    element_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tleq_pkg::STAT_W-1:0]  status_o,
  output logic [tleq_pkg::OUT_W-1:0]   oldest_queued_o,
  output logic [tleq_pkg::OUT_W-1:0]   queued_count_o,
  output logic [tleq_pkg::OUT_W-1:0]   active_count_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NONE = LW'(ENTRIES);
  localparam logic [LW-1:0] LAST = LW'(ENTRIES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UNL  = 3'd2;
  localparam logic [2:0] ST_APP  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;
  localparam logic [2:0] ST_RES  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [tleq_pkg::CFG_W-1:0] entries_in_use_q, max_active_q;

  logic [LW-1:0] q_old_q, q_old_d, q_new_q, q_new_d, q_size_q, q_size_d;
  logic [LW-1:0] a_old_q, a_old_d, a_new_q, a_new_d, a_size_q, a_size_d;
  logic [LW-1:0] pool_q, pool_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] e_q, e_d;
  logic          to_act_q, to_act_d;
  logic          flush_q, flush_d;
  logic [tleq_pkg::STAT_W-1:0] stat_q, stat_d;
  logic          tail_ok_q, tail_ok_d;

  logic out_valid_q;
  logic [tleq_pkg::STAT_W-1:0] status_q;
  logic [tleq_pkg::OUT_W-1:0]  oldest_q, qcnt_q, acnt_q;

  // memory ports; the active flag rides with the prev link
  logic          nx_we, pv_we;
  logic [AW-1:0] nx_wa, pv_wa;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic          ac_wd, ac_rd;
  logic [LW:0]   pv_mem_rd;

  logic [LW-1:0] p_l, n_l, tail, others, clamp_n;
  logic          cfg_we;

  tleq_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(e_q), .rdata_o(nx_rd)
  );
  tleq_ram #(.WIDTH(LW + 1), .DEPTH(ENTRIES)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i({ac_wd, pv_wd}), .raddr_i(e_q),
    .rdata_o(pv_mem_rd)
  );

  assign pv_rd = pv_mem_rd[LW-1:0];
  assign ac_rd = pv_mem_rd[LW];

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == tleq_pkg::REG_MAX_ACTIVE) ? 32'(max_active_q)
                                                         : 32'(entries_in_use_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= tleq_pkg::ENTRIES_IN_USE_RST;
      max_active_q     <= tleq_pkg::MAX_ACTIVE_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        tleq_pkg::REG_ENTRIES_IN_USE: entries_in_use_q <= pwdata[tleq_pkg::CFG_W-1:0];
        tleq_pkg::REG_MAX_ACTIVE:     max_active_q     <= pwdata[tleq_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign p_l    = pv_rd;
  assign n_l    = nx_rd;
  assign others = a_size_q - LW'(ac_rd);
  assign tail   = to_act_q ? ((a_size_q == '0) ? NONE : a_new_q)
                           : ((q_size_q == '0) ? NONE : q_new_q);

  always_comb begin
    if (32'(entries_in_use_q) < 32'd2) begin
      clamp_n = LW'(2);
    end else if (32'(entries_in_use_q) > ENTRIES) begin
      clamp_n = NONE;
    end else begin
      clamp_n = LW'(entries_in_use_q);
    end
  end

  always_comb begin
    state_d   = state_q;
    q_old_d   = q_old_q;
    q_new_d   = q_new_q;
    q_size_d  = q_size_q;
    a_old_d   = a_old_q;
    a_new_d   = a_new_q;
    a_size_d  = a_size_q;
    pool_d    = pool_q;
    cnt_d     = cnt_q;
    e_d       = e_q;
    to_act_d  = to_act_q;
    flush_d   = flush_q;
    stat_d    = stat_q;
    tail_ok_d = tail_ok_q;
    nx_we = 1'b0; nx_wa = e_q; nx_wd = NONE;
    pv_we = 1'b0; pv_wa = e_q; pv_wd = NONE;
    ac_wd = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          stat_d  = tleq_pkg::STAT_DONE;
          flush_d = 1'b0;
          case (kind_i)
            tleq_pkg::KIND_ACTIVATE: begin
              if (32'(element_id_i) >= 32'(pool_q) || 32'(element_id_i) >= ENTRIES) begin
                stat_d  = tleq_pkg::STAT_BAD_ID;
                state_d = ST_RES;
              end else begin
                e_d      = AW'(element_id_i);
                to_act_d = 1'b1;
                state_d  = ST_RD;
              end
            end
            tleq_pkg::KIND_FLUSH: begin
              flush_d  = 1'b1;
              to_act_d = 1'b0;
              if (a_size_q != '0 && a_old_q < NONE) begin
                e_d     = a_old_q[AW-1:0];
                state_d = ST_RD;
              end else begin
                state_d = ST_RES;
              end
            end
            tleq_pkg::KIND_CLEAR: begin
              pool_d   = clamp_n;
              cnt_d    = '0;
              q_old_d  = '0;
              q_new_d  = clamp_n - LW'(1);
              q_size_d = clamp_n;
              a_old_d  = NONE;
              a_new_d  = NONE;
              a_size_d = '0;
              state_d  = ST_CLR;
            end
            default: state_d = ST_RES;
          endcase
        end
      end
      ST_RD: state_d = ST_UNL;
      ST_UNL: begin
        if (to_act_q && 32'(others) >= 32'(max_active_q)) begin
          stat_d  = tleq_pkg::STAT_FULL;
          state_d = ST_RES;
        end else begin
          // the next neighbor sits in the same list, so its flag equals ours
          nx_we = p_l < NONE; nx_wa = p_l[AW-1:0]; nx_wd = n_l;
          pv_we = n_l < NONE; pv_wa = n_l[AW-1:0]; pv_wd = p_l; ac_wd = ac_rd;
          if (ac_rd) begin
            if (a_old_q == LW'(e_q)) a_old_d = n_l;
            if (a_new_q == LW'(e_q)) a_new_d = p_l;
            if (a_size_q != '0) a_size_d = a_size_q - LW'(1);
          end else begin
            if (q_old_q == LW'(e_q)) q_old_d = n_l;
            if (q_new_q == LW'(e_q)) q_new_d = p_l;
            if (q_size_q != '0) q_size_d = q_size_q - LW'(1);
          end
          state_d = ST_APP;
        end
      end
      ST_APP: begin
        pv_we = 1'b1; pv_wd = tail; ac_wd = to_act_q;
        tail_ok_d = tail < NONE;
        if (tail < NONE) begin
          nx_we = 1'b1; nx_wa = tail[AW-1:0]; nx_wd = LW'(e_q);
        end else begin
          nx_we = 1'b1; nx_wd = NONE;
          if (to_act_q) a_old_d = LW'(e_q);
          else          q_old_d = LW'(e_q);
        end
        if (to_act_q) begin
          a_new_d  = LW'(e_q);
          a_size_d = a_size_q + LW'(1);
        end else begin
          q_new_d  = LW'(e_q);
          q_size_d = q_size_q + LW'(1);
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // terminate the new tail
        nx_we = tail_ok_q; nx_wd = NONE;
        if (flush_q && a_size_q != '0 && a_old_q < NONE) begin
          e_d     = a_old_q[AW-1:0];
          state_d = ST_RD;
        end else begin
          state_d = ST_RES;
        end
      end
      ST_CLR: begin
        nx_we = 1'b1; nx_wa = cnt_q[AW-1:0];
        pv_we = 1'b1; pv_wa = cnt_q[AW-1:0];
        nx_wd = (cnt_q + LW'(1) < pool_q) ? cnt_q + LW'(1) : NONE;
        pv_wd = (cnt_q < pool_q && cnt_q != '0) ? cnt_q - LW'(1) : NONE;
        cnt_d = cnt_q + LW'(1);
        if (cnt_q == LAST) begin
          state_d = flush_q ? ST_IDLE : ST_RES;
          flush_d = 1'b0;
        end
      end
      ST_RES: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      q_old_q   <= '0;
      q_new_q   <= LAST;
      q_size_q  <= NONE;
      a_old_q   <= NONE;
      a_new_q   <= NONE;
      a_size_q  <= '0;
      pool_q    <= NONE;
      cnt_q     <= '0;
      e_q       <= '0;
      to_act_q  <= 1'b0;
      flush_q   <= 1'b1;  // reset sweep returns no result
      stat_q    <= tleq_pkg::STAT_DONE;
      tail_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      q_old_q   <= q_old_d;
      q_new_q   <= q_new_d;
      q_size_q  <= q_size_d;
      a_old_q   <= a_old_d;
      a_new_q   <= a_new_d;
      a_size_q  <= a_size_d;
      pool_q    <= pool_d;
      cnt_q     <= cnt_d;
      e_q       <= e_d;
      to_act_q  <= to_act_d;
      flush_q   <= flush_d;
      stat_q    <= stat_d;
      tail_ok_q <= tail_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RES && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RES && (!out_valid_q || out_ready_i)) begin
      status_q <= stat_q;
      oldest_q <= (q_size_q == '0) ? tleq_pkg::OUT_W'(NONE) : tleq_pkg::OUT_W'(q_old_q);
      qcnt_q   <= tleq_pkg::OUT_W'(q_size_q);
      acnt_q   <= tleq_pkg::OUT_W'(a_size_q);
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign oldest_queued_o = oldest_q;
  assign queued_count_o  = qcnt_q;
  assign active_count_o  = acnt_q;

endmodule
